>>> sv/sbc_pkg.sv
// ---------------------------------------------------------------------------
// sbc_pkg : shared types, tables and a function for the compression block
// sbox, linear transform rows, iteration constants and the sequencer states
// ---------------------------------------------------------------------------
`default_nettype none
package sbc_pkg;

	localparam int unsigned Words  = 8;
	localparam int unsigned Rounds = 12;

	typedef logic [63:0] word_t;
	typedef word_t [7:0] block_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_KEY,
		ST_DATA,
		ST_RKEY,
		ST_RDATA,
		ST_OUT
	} state_t;

	localparam logic [7:0] SBOX [256] = '{
		8'd252, 8'd238, 8'd221, 8'd17, 8'd207, 8'd110, 8'd49, 8'd22,
		8'd251, 8'd196, 8'd250, 8'd218, 8'd35, 8'd197, 8'd4, 8'd77,
		8'd233, 8'd119, 8'd240, 8'd219, 8'd147, 8'd46, 8'd153, 8'd186,
		8'd23, 8'd54, 8'd241, 8'd187, 8'd20, 8'd205, 8'd95, 8'd193,
		8'd249, 8'd24, 8'd101, 8'd90, 8'd226, 8'd92, 8'd239, 8'd33,
		8'd129, 8'd28, 8'd60, 8'd66, 8'd139, 8'd1, 8'd142, 8'd79,
		8'd5, 8'd132, 8'd2, 8'd174, 8'd227, 8'd106, 8'd143, 8'd160,
		8'd6, 8'd11, 8'd237, 8'd152, 8'd127, 8'd212, 8'd211, 8'd31,
		8'd235, 8'd52, 8'd44, 8'd81, 8'd234, 8'd200, 8'd72, 8'd171,
		8'd242, 8'd42, 8'd104, 8'd162, 8'd253, 8'd58, 8'd206, 8'd204,
		8'd181, 8'd112, 8'd14, 8'd86, 8'd8, 8'd12, 8'd118, 8'd18,
		8'd191, 8'd114, 8'd19, 8'd71, 8'd156, 8'd183, 8'd93, 8'd135,
		8'd21, 8'd161, 8'd150, 8'd41, 8'd16, 8'd123, 8'd154, 8'd199,
		8'd243, 8'd145, 8'd120, 8'd111, 8'd157, 8'd158, 8'd178, 8'd177,
		8'd50, 8'd117, 8'd25, 8'd61, 8'd255, 8'd53, 8'd138, 8'd126,
		8'd109, 8'd84, 8'd198, 8'd128, 8'd195, 8'd189, 8'd13, 8'd87,
		8'd223, 8'd245, 8'd36, 8'd169, 8'd62, 8'd168, 8'd67, 8'd201,
		8'd215, 8'd121, 8'd214, 8'd246, 8'd124, 8'd34, 8'd185, 8'd3,
		8'd224, 8'd15, 8'd236, 8'd222, 8'd122, 8'd148, 8'd176, 8'd188,
		8'd220, 8'd232, 8'd40, 8'd80, 8'd78, 8'd51, 8'd10, 8'd74,
		8'd167, 8'd151, 8'd96, 8'd115, 8'd30, 8'd0, 8'd98, 8'd68,
		8'd26, 8'd184, 8'd56, 8'd130, 8'd100, 8'd159, 8'd38, 8'd65,
		8'd173, 8'd69, 8'd70, 8'd146, 8'd39, 8'd94, 8'd85, 8'd47,
		8'd140, 8'd163, 8'd165, 8'd125, 8'd105, 8'd213, 8'd149, 8'd59,
		8'd7, 8'd88, 8'd179, 8'd64, 8'd134, 8'd172, 8'd29, 8'd247,
		8'd48, 8'd55, 8'd107, 8'd228, 8'd136, 8'd217, 8'd231, 8'd137,
		8'd225, 8'd27, 8'd131, 8'd73, 8'd76, 8'd63, 8'd248, 8'd254,
		8'd141, 8'd83, 8'd170, 8'd144, 8'd202, 8'd216, 8'd133, 8'd97,
		8'd32, 8'd113, 8'd103, 8'd164, 8'd45, 8'd43, 8'd9, 8'd91,
		8'd203, 8'd155, 8'd37, 8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
		8'd89, 8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192,
		8'd209, 8'd102, 8'd175, 8'd194, 8'd57, 8'd75, 8'd99, 8'd182
	};

	localparam word_t LIN_ROWS [64] = '{
		64'h8e20faa72ba0b470, 64'h47107ddd9b505a38, 64'had08b0e0c3282d1c, 64'hd8045870ef14980e,
		64'h6c022c38f90a4c07, 64'h3601161cf205268d, 64'h1b8e0b0e798c13c8, 64'h83478b07b2468764,
		64'ha011d380818e8f40, 64'h5086e740ce47c920, 64'h2843fd2067adea10, 64'h14aff010bdd87508,
		64'h0ad97808d06cb404, 64'h05e23c0468365a02, 64'h8c711e02341b2d01, 64'h46b60f011a83988e,
		64'h90dab52a387ae76f, 64'h486dd4151c3dfdb9, 64'h24b86a840e90f0d2, 64'h125c354207487869,
		64'h092e94218d243cba, 64'h8a174a9ec8121e5d, 64'h4585254f64090fa0, 64'haccc9ca9328a8950,
		64'h9d4df05d5f661451, 64'hc0a878a0a1330aa6, 64'h60543c50de970553, 64'h302a1e286fc58ca7,
		64'h18150f14b9ec46dd, 64'h0c84890ad27623e0, 64'h0642ca05693b9f70, 64'h0321658cba93c138,
		64'h86275df09ce8aaa8, 64'h439da0784e745554, 64'hafc0503c273aa42a, 64'hd960281e9d1d5215,
		64'he230140fc0802984, 64'h71180a8960409a42, 64'hb60c05ca30204d21, 64'h5b068c651810a89e,
		64'h456c34887a3805b9, 64'hac361a443d1c8cd2, 64'h561b0d22900e4669, 64'h2b838811480723ba,
		64'h9bcf4486248d9f5d, 64'hc3e9224312c8c1a0, 64'heffa11af0964ee50, 64'hf97d86d98a327728,
		64'he4fa2054a80b329c, 64'h727d102a548b194e, 64'h39b008152acb8227, 64'h9258048415eb419d,
		64'h492c024284fbaec0, 64'haa16012142f35760, 64'h550b8e9e21f7a530, 64'ha48b474f9ef5dc18,
		64'h70a6a56e2440598e, 64'h3853dc371220a247, 64'h1ca76e95091051ad, 64'h0edd37c48a08a6d8,
		64'h07e095624504536c, 64'h8d70c431ac02a736, 64'hc83862965601dd1b, 64'h641c314b2b8ee083
	};

	localparam word_t ITER_C [96] = '{
		64'hb1085bda1ecadae9, 64'hebcb2f81c0657c1f, 64'h2f6a76432e45d016, 64'h714eb88d7585c4fc,
		64'h4b7ce09192676901, 64'ha2422a08a460d315, 64'h05767436cc744d23, 64'hdd806559f2a64507,
		64'h6fa3b58aa99d2f1a, 64'h4fe39d460f70b5d7, 64'hf3feea720a232b98, 64'h61d55e0f16b50131,
		64'h9ab5176b12d69958, 64'h5cb561c2db0aa7ca, 64'h55dda21bd7cbcd56, 64'he679047021b19bb7,
		64'hf574dcac2bce2fc7, 64'h0a39fc286a3d8435, 64'h06f15e5f529c1f8b, 64'hf2ea7514b1297b7b,
		64'hd3e20fe490359eb1, 64'hc1c93a376062db09, 64'hc2b6f443867adb31, 64'h991e96f50aba0ab2,
		64'hef1fdfb3e81566d2, 64'hf948e1a05d71e4dd, 64'h488e857e335c3c7d, 64'h9d721cad685e353f,
		64'ha9d72c82ed03d675, 64'hd8b71333935203be, 64'h3453eaa193e837f1, 64'h220cbebc84e3d12e,
		64'h4bea6bacad474799, 64'h9a3f410c6ca92363, 64'h7f151c1f1686104a, 64'h359e35d7800fffbd,
		64'hbfcd1747253af5a3, 64'hdfff00b723271a16, 64'h7a56a27ea9ea63f5, 64'h601758fd7c6cfe57,
		64'hae4faeae1d3ad3d9, 64'h6fa4c33b7a3039c0, 64'h2d66c4f95142a46c, 64'h187f9ab49af08ec6,
		64'hcffaa6b71c9ab7b4, 64'h0af21f66c2bec6b6, 64'hbf71c57236904f35, 64'hfa68407a46647d6e,
		64'hf4c70e16eeaac5ec, 64'h51ac86febf240954, 64'h399ec6c7e6bf87c9, 64'hd3473e33197a93c9,
		64'h0992abc52d822c37, 64'h06476983284a0504, 64'h3517454ca23c4af3, 64'h8886564d3a14d493,
		64'h9b1f5b424d93c9a7, 64'h03e7aa020c6e4141, 64'h4eb7f8719c36de1e, 64'h89b4443b4ddbc49a,
		64'hf4892bcb929b0690, 64'h69d18d2bd1a5c42f, 64'h36acc2355951a8d9, 64'ha47f0dd4bf02e71e,
		64'h378f5a541631229b, 64'h944c9ad8ec165fde, 64'h3a7d3a1b25894224, 64'h3cd955b7e00d0984,
		64'h800a440bdbb2ceb1, 64'h7b2b8a9aa6079c54, 64'h0e38dc92cb1f2a60, 64'h7261445183235adb,
		64'habbedea680056f52, 64'h382ae548b2e4f3f3, 64'h8941e71cff8a78db, 64'h1fffe18a1b336103,
		64'h9fe76702af69334b, 64'h7a1e6c303b7652f4, 64'h3698fad1153bb6c3, 64'h74b4c7fb98459ced,
		64'h7bcd9ed0efc889fb, 64'h3002c6cd635afe94, 64'hd8fa6bbbebab0761, 64'h2001802114846679,
		64'h8a1d71efea48b9ca, 64'hefbacd1d7d476e98, 64'hdea2594ac06fd85d, 64'h6bcaa4cd81f32d1b,
		64'h378ee767f11631ba, 64'hd21380b00449b17a, 64'hcda43c32bcdf1d77, 64'hf82012d430219f9b,
		64'h5d80ef9d1891cc86, 64'he71da4aa88e12852, 64'hfaf417d5d9b21b99, 64'h48bc924af11bd720
	};

	// linear transform of one word: xor of matrix rows selected by its bits
	function automatic word_t lin_word(input word_t w);
		word_t acc;
		acc = '0;
		for (int b = 0; b < 64; b++) begin
			if (w[b]) acc = acc ^ LIN_ROWS[63 - b];
		end
		return acc;
	endfunction

endpackage
`default_nettype wire

>>> sv/streebog_compress.sv
// ---------------------------------------------------------------------------
// streebog_compress : gost r 34.11-2012 compression function g_N
// loads h, N and m a word per item, runs 12 rounds on a shared lps unit and
// returns the new chaining value as eight result items
// ---------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: chain_word, counter_word, message_word, word_index
// m_axis    out  tdata: result_word, result_index; tlast: last_word
//
// items with index 0..6 are taken while the sequencer is in ST_LOAD
// index 7 starts 25 lps passes, one output word per cycle through
//   a single sbox/linear lane, then 8 results
// the result register stalls on m_axis_tready; no input is taken meanwhile
// reset clears the sequencer only; stores are undefined until loaded
`default_nettype none
module streebog_compress (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// chain_word[63:0], counter_word[127:64], message_word[191:128],
	// word_index[194:192], zero fill to 200
	input  wire logic [199:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// result_word[63:0], result_index[66:64], zero fill to 72
	output logic [71:0]       m_axis_tdata,
	output logic              m_axis_tlast
);

	sbc_pkg::state_t state_q, state_nx;
	sbc_pkg::block_t h_q, n_q, m_q, key_q, dat_q, acc_q;
	logic [3:0] round_q;
	logic [2:0] col_q;
	logic [2:0] out_idx_q;

	logic s_acc, m_acc, col_end;
	logic [2:0] in_idx;
	sbc_pkg::block_t op_a, op_b, op_x;
	sbc_pkg::word_t lane_w, lane_r;
	logic [6:0] c_base;

	assign in_idx  = s_axis_tdata[194:192];
	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign m_acc   = m_axis_tvalid && m_axis_tready;
	assign col_end = (col_q == 3'd7);
	assign c_base  = 7'(round_q) * 7'd8;

	// operand selection for the shared lps unit
	always_comb begin
		op_a = key_q;
		op_b = dat_q;
		for (int j = 0; j < 8; j++) begin
			case (state_q)
				sbc_pkg::ST_KEY: begin
					op_a[j] = h_q[j];
					op_b[j] = n_q[j];
				end
				sbc_pkg::ST_DATA: begin
					op_b[j] = m_q[j];
				end
				sbc_pkg::ST_RKEY: begin
					op_b[j] = sbc_pkg::ITER_C[c_base + 7'(j)];
				end
				default: begin
					op_b[j] = dat_q[j];
				end
			endcase
		end
	end

	assign op_x = op_a ^ op_b;

	// one output word of lps: byte col of every xored word through the sbox
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			lane_w[8*j +: 8] = sbc_pkg::SBOX[op_x[j][8*col_q +: 8]];
		end
		lane_r = sbc_pkg::lin_word(lane_w);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			sbc_pkg::ST_LOAD:  if (s_acc && in_idx == 3'd7) state_nx = sbc_pkg::ST_KEY;
			sbc_pkg::ST_KEY:   if (col_end) state_nx = sbc_pkg::ST_DATA;
			sbc_pkg::ST_DATA:  if (col_end) state_nx = sbc_pkg::ST_RKEY;
			sbc_pkg::ST_RKEY: begin
				if (col_end) state_nx = (round_q == 4'd11) ? sbc_pkg::ST_OUT : sbc_pkg::ST_RDATA;
			end
			sbc_pkg::ST_RDATA: if (col_end) state_nx = sbc_pkg::ST_RKEY;
			sbc_pkg::ST_OUT:   if (m_acc && out_idx_q == 3'd7) state_nx = sbc_pkg::ST_LOAD;
			default:           state_nx = sbc_pkg::ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = (state_q == sbc_pkg::ST_LOAD);
		m_axis_tvalid = (state_q == sbc_pkg::ST_OUT);
		m_axis_tdata  = {5'd0, out_idx_q, acc_q[out_idx_q] ^ h_q[out_idx_q] ^ m_q[out_idx_q]};
		m_axis_tlast  = (out_idx_q == 3'd7);
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sbc_pkg::ST_LOAD;
			round_q   <= '0;
			col_q     <= '0;
			out_idx_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == sbc_pkg::ST_LOAD) col_q <= '0;
			else if (state_q != sbc_pkg::ST_OUT) col_q <= col_q + 3'd1;
			if (state_q == sbc_pkg::ST_LOAD) round_q <= '0;
			else if (state_q == sbc_pkg::ST_RKEY && col_end && round_q != 4'd11)
				round_q <= round_q + 4'd1;
			if (m_acc) out_idx_q <= out_idx_q + 3'd1;
		end
	end

	// operand stores and working block
	always_ff @(posedge clk) begin
		if (s_acc) begin
			h_q[in_idx] <= s_axis_tdata[63:0];
			n_q[in_idx] <= s_axis_tdata[127:64];
			m_q[in_idx] <= s_axis_tdata[191:128];
		end
		if (col_end && state_q == sbc_pkg::ST_RKEY && round_q == 4'd11) begin
			// last round: output block is new key xor data
			acc_q <= {lane_r ^ dat_q[7], acc_q[6:0] ^ dat_q[6:0]};
		end else if (state_q != sbc_pkg::ST_LOAD && state_q != sbc_pkg::ST_OUT) begin
			acc_q[col_q] <= lane_r;
		end
		if (col_end) begin
			case (state_q)
				sbc_pkg::ST_KEY, sbc_pkg::ST_RKEY: begin
					key_q <= {lane_r, acc_q[6:0]};
				end
				sbc_pkg::ST_DATA, sbc_pkg::ST_RDATA: begin
					dat_q <= {lane_r, acc_q[6:0]};
				end
				default: begin
				end
			endcase
		end
	end

	// assertions
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while results pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed under stall");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && in_idx == 3'd7) |=> (state_q == sbc_pkg::ST_KEY && col_q == 3'd0))
		else $error("computation did not start");
	a_out_begin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> (out_idx_q == 3'd0))
		else $error("results do not start at word zero");

endmodule
`default_nettype wire
